### rtl/gconv_pkg.sv
// shared constants, codes and item types of the grouped convolution engine
`default_nettype none
package gconv_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int MAX_WIDTH    = 32;
	localparam int MAX_KERNEL   = 5;
	localparam int DATA_BITS    = 16;

	localparam int ACT_DEPTH  = MAX_CHANNELS * MAX_WIDTH * MAX_WIDTH;
	localparam int WGT_DEPTH  = MAX_CHANNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
	localparam int BIAS_DEPTH = MAX_CHANNELS;
	localparam int ACT_AW     = $clog2(ACT_DEPTH);
	localparam int WGT_AW     = $clog2(WGT_DEPTH);
	localparam int BIAS_AW    = $clog2(BIAS_DEPTH);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// item modes
	localparam logic [1:0] MODE_WGT  = 2'd0;
	localparam logic [1:0] MODE_BIAS = 2'd1;
	localparam logic [1:0] MODE_ACT  = 2'd2;
	localparam logic [1:0] MODE_READ = 2'd3;

	// register indexes
	localparam logic [2:0] REG_IN_CH  = 3'd0;
	localparam logic [2:0] REG_OUT_CH = 3'd1;
	localparam logic [2:0] REG_WIDTH  = 3'd2;
	localparam logic [2:0] REG_KERNEL = 3'd3;
	localparam logic [2:0] REG_PAD    = 3'd4;
	localparam logic [2:0] REG_STRIDE = 3'd5;
	localparam logic [2:0] REG_GROUPS = 3'd6;
	localparam logic [2:0] REG_BIAS   = 3'd7;

	typedef struct packed {
		logic [1:0]         mode;
		logic [13:0]        index;
		logic signed [15:0] value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               status;
	} res_t;

	typedef struct packed {
		logic [4:0] in_channels;
		logic [4:0] out_channels;
		logic [5:0] in_width;
		logic [2:0] kernel_width;
		logic [1:0] pad_width;
		logic [2:0] stride_step;
		logic [4:0] group_count;
		logic       bias_enable;
	} cfg_t;

	// decoded item handed from front to back
	typedef struct packed {
		logic [1:0]         mode;
		logic               bad;
		logic [13:0]        index;
		logic signed [15:0] value;
		logic [3:0]         oc;
		logic [5:0]         orow;
		logic [5:0]         ocol;
		logic [4:0]         ig;
		logic [3:0]         grp;
	} cmd_t;

endpackage
`default_nettype wire

### rtl/gconv_front.sv
// front end: accepts items, checks the configuration and splits read indexes
`default_nettype none
module gconv_front import gconv_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire item_t item,
	input  wire logic  item_valid,
	output logic       item_ready,
	output cmd_t       cmd,
	output logic       cmd_valid,
	input  wire logic  cmd_ready
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_DIV  = 3'd1;
	localparam logic [2:0] F_MUL1 = 3'd2;
	localparam logic [2:0] F_MUL2 = 3'd3;
	localparam logic [2:0] F_CHK  = 3'd4;
	localparam logic [2:0] F_PUSH = 3'd5;

	localparam logic [2:0] DV_IG  = 3'd0;
	localparam logic [2:0] DV_OG  = 3'd1;
	localparam logic [2:0] DV_OW  = 3'd2;
	localparam logic [2:0] DV_OC  = 3'd3;
	localparam logic [2:0] DV_ROW = 3'd4;
	localparam logic [2:0] DV_G   = 3'd5;

	logic [2:0]  state_q;
	logic [2:0]  div_sel_q;
	logic [13:0] num_q;
	logic [10:0] den_q;
	logic [5:0]  quo_q;
	cmd_t        cmd_q;
	logic [4:0]  ig_q;
	logic [4:0]  og_q;
	logic [5:0]  ow_q;
	logic [10:0] osz_q;
	logic [14:0] total_q;

	logic        base_ok;
	logic [6:0]  pw;
	logic        pw_ok;
	logic        div_ge;

	assign base_ok = (cfg.in_channels != 5'd0) && (cfg.in_channels <= 5'(MAX_CHANNELS)) &&
		(cfg.out_channels != 5'd0) && (cfg.out_channels <= 5'(MAX_CHANNELS)) &&
		(cfg.in_width != 6'd0) && (cfg.in_width <= 6'(MAX_WIDTH)) &&
		(cfg.kernel_width != 3'd0) && (cfg.kernel_width <= 3'(MAX_KERNEL)) &&
		(cfg.stride_step != 3'd0) && (cfg.group_count != 5'd0);
	assign pw     = {1'b0, cfg.in_width} + {4'b0, cfg.pad_width, 1'b0};
	assign pw_ok  = pw >= {4'b0, cfg.kernel_width};
	assign div_ge = num_q >= {3'b0, den_q};

	assign item_ready = (state_q == F_IDLE);
	assign cmd_valid  = (state_q == F_PUSH);
	assign cmd        = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (item_valid) begin
						cmd_q.mode  <= item.mode;
						cmd_q.index <= item.index;
						cmd_q.value <= item.value;
						cmd_q.bad   <= 1'b0;
						cmd_q.oc    <= 4'd0;
						cmd_q.orow  <= 6'd0;
						cmd_q.ocol  <= 6'd0;
						cmd_q.ig    <= 5'd0;
						cmd_q.grp   <= 4'd0;
						if (item.mode != MODE_READ) begin
							state_q <= F_PUSH;
						end else if (!base_ok) begin
							cmd_q.bad <= 1'b1;
							state_q   <= F_PUSH;
						end else begin
							num_q     <= {9'b0, cfg.in_channels};
							den_q     <= {6'b0, cfg.group_count};
							quo_q     <= 6'd0;
							div_sel_q <= DV_IG;
							state_q   <= F_DIV;
						end
					end
				end
				F_DIV: begin
					if (div_ge) begin
						num_q <= num_q - {3'b0, den_q};
						quo_q <= quo_q + 6'd1;
					end else begin
						unique case (div_sel_q)
							DV_IG: begin
								if (num_q != 14'd0) begin
									cmd_q.bad <= 1'b1;
									state_q   <= F_PUSH;
								end else begin
									ig_q      <= quo_q[4:0];
									num_q     <= {9'b0, cfg.out_channels};
									den_q     <= {6'b0, cfg.group_count};
									quo_q     <= 6'd0;
									div_sel_q <= DV_OG;
								end
							end
							DV_OG: begin
								if (num_q != 14'd0 || !pw_ok) begin
									cmd_q.bad <= 1'b1;
									state_q   <= F_PUSH;
								end else begin
									og_q      <= quo_q[4:0];
									num_q     <= {7'b0, pw - {4'b0, cfg.kernel_width}};
									den_q     <= {8'b0, cfg.stride_step};
									quo_q     <= 6'd0;
									div_sel_q <= DV_OW;
								end
							end
							DV_OW: begin
								ow_q    <= quo_q + 6'd1;
								state_q <= F_MUL1;
							end
							DV_OC: begin
								// remainder stays in num_q as the position
								cmd_q.oc  <= quo_q[3:0];
								den_q     <= {5'b0, ow_q};
								quo_q     <= 6'd0;
								div_sel_q <= DV_ROW;
							end
							DV_ROW: begin
								cmd_q.orow <= quo_q;
								cmd_q.ocol <= num_q[5:0];
								num_q      <= {10'b0, cmd_q.oc};
								den_q      <= {6'b0, og_q};
								quo_q      <= 6'd0;
								div_sel_q  <= DV_G;
							end
							DV_G: begin
								cmd_q.grp <= quo_q[3:0];
								cmd_q.ig  <= ig_q;
								state_q   <= F_PUSH;
							end
							default: begin
								state_q <= F_IDLE;
							end
						endcase
					end
				end
				F_MUL1: begin
					osz_q   <= {5'b0, ow_q} * {5'b0, ow_q};
					state_q <= F_MUL2;
				end
				F_MUL2: begin
					total_q <= {10'b0, cfg.out_channels} * {4'b0, osz_q};
					state_q <= F_CHK;
				end
				F_CHK: begin
					if ({1'b0, cmd_q.index} >= total_q) begin
						cmd_q.bad <= 1'b1;
						state_q   <= F_PUSH;
					end else begin
						num_q     <= cmd_q.index;
						den_q     <= osz_q;
						quo_q     <= 6'd0;
						div_sel_q <= DV_OC;
						state_q   <= F_DIV;
					end
				end
				F_PUSH: begin
					if (cmd_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/gconv_queue.sv
// short queue of decoded items between front and back
`default_nettype none
module gconv_queue import gconv_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t push_cmd,
	input  wire logic push_valid,
	output logic      push_ready,
	output cmd_t      pop_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready
);

	cmd_t                  slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = count_q != (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/gconv_back.sv
// back end: store writes and the multiply-accumulate walk over one output element
`default_nettype none
module gconv_back import gconv_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire cmd_t cmd,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	output res_t      res,
	output logic      res_valid,
	input  wire logic res_ready
);

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_SET1  = 3'd1;
	localparam logic [2:0] B_SET2  = 3'd2;
	localparam logic [2:0] B_SET3  = 3'd3;
	localparam logic [2:0] B_RUN   = 3'd4;
	localparam logic [2:0] B_DRAIN = 3'd5;
	localparam logic [2:0] B_BIAS  = 3'd6;
	localparam logic [2:0] B_OUT   = 3'd7;

	logic signed [15:0] act_mem  [ACT_DEPTH];
	logic signed [15:0] wgt_mem  [WGT_DEPTH];
	logic signed [15:0] bias_mem [BIAS_DEPTH];

	logic [2:0]         state_q;
	cmd_t               cmd_q;
	logic               bad_q;
	logic [11:0]        w2_q;
	logic [3:0]         ic0_q;
	logic [8:0]         oig_q;
	logic [4:0]         kk_q;
	logic signed [10:0] r0_q;
	logic signed [10:0] c0_q;
	logic signed [10:0] r_cur_q;
	logic signed [10:0] c_cur_q;
	logic signed [16:0] chan_q;
	logic signed [16:0] row_off_q;
	logic signed [16:0] row_base_q;
	logic [WGT_AW-1:0]  wptr_q;
	logic [4:0]         k_q;
	logic [2:0]         kr_q;
	logic [2:0]         kc_q;
	logic               drain_q;
	logic signed [47:0] acc_q;
	logic signed [15:0] bias_rd_q;
	logic signed [15:0] act_rd_s1;
	logic signed [15:0] wgt_rd_s1;
	logic               tap_s1;
	logic signed [31:0] prod_s2;
	logic               tap_s2;
	res_t               res_q;
	logic               res_valid_q;

	logic               take;
	logic               tap_ok;
	logic signed [16:0] ai_full;
	logic signed [16:0] r0_ext;
	logic signed [10:0] width_s;
	logic [8:0]         orow_str;
	logic [8:0]         ocol_str;
	logic               out_free;
	logic               last_kc;
	logic               last_kr;
	logic               last_k;
	logic signed [31:0] sat_val;

	assign cmd_ready = (state_q == B_IDLE);
	assign take      = cmd_valid && (state_q == B_IDLE);
	assign width_s   = $signed({5'b0, cfg.in_width});
	assign tap_ok    = (r_cur_q >= 11'sd0) && (r_cur_q < width_s) &&
		(c_cur_q >= 11'sd0) && (c_cur_q < width_s);
	assign ai_full   = row_base_q + {{6{c_cur_q[10]}}, c_cur_q};
	assign r0_ext    = {{6{r0_q[10]}}, r0_q};
	assign orow_str  = {3'b0, cmd_q.orow} * {6'b0, cfg.stride_step};
	assign ocol_str  = {3'b0, cmd_q.ocol} * {6'b0, cfg.stride_step};
	assign out_free  = !res_valid_q || res_ready;
	assign last_kc   = kc_q == cfg.kernel_width - 3'd1;
	assign last_kr   = kr_q == cfg.kernel_width - 3'd1;
	assign last_k    = k_q == cmd_q.ig - 5'd1;

	// saturate to the 32-bit result range
	always_comb begin
		if (acc_q[47:31] == {17{1'b0}} || acc_q[47:31] == {17{1'b1}}) begin
			sat_val = acc_q[31:0];
		end else if (acc_q[47]) begin
			sat_val = 32'sh8000_0000;
		end else begin
			sat_val = 32'sh7FFF_FFFF;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

	// stores: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (take && cmd.mode == MODE_ACT) begin
			act_mem[cmd.index[ACT_AW-1:0]] <= cmd.value;
		end
		act_rd_s1 <= act_mem[ai_full[ACT_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (take && cmd.mode == MODE_WGT && {1'b0, cmd.index} < 15'(WGT_DEPTH)) begin
			wgt_mem[cmd.index[WGT_AW-1:0]] <= cmd.value;
		end
		wgt_rd_s1 <= wgt_mem[wptr_q];
	end

	always_ff @(posedge clk) begin
		if (take && cmd.mode == MODE_BIAS && cmd.index < 14'(BIAS_DEPTH)) begin
			bias_mem[cmd.index[BIAS_AW-1:0]] <= cmd.value;
		end
		bias_rd_q <= bias_mem[cmd_q.oc];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= act_rd_s1 * wgt_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= 1'b0;
			tap_s2 <= 1'b0;
		end else begin
			tap_s1 <= (state_q == B_RUN) && tap_ok;
			tap_s2 <= tap_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (take && cmd.mode == MODE_READ) begin
						cmd_q <= cmd;
						acc_q <= '0;
						bad_q <= cmd.bad;
						state_q <= cmd.bad ? B_OUT : B_SET1;
					end
				end
				B_SET1: begin
					w2_q  <= {6'b0, cfg.in_width} * {6'b0, cfg.in_width};
					ic0_q <= 4'({4'b0, cmd_q.grp} * {4'b0, cmd_q.ig});
					oig_q <= {5'b0, cmd_q.oc} * {4'b0, cmd_q.ig};
					kk_q  <= {2'b0, cfg.kernel_width} * {2'b0, cfg.kernel_width};
					r0_q  <= $signed({2'b0, orow_str}) - $signed({9'b0, cfg.pad_width});
					c0_q  <= $signed({2'b0, ocol_str}) - $signed({9'b0, cfg.pad_width});
					state_q <= B_SET2;
				end
				B_SET2: begin
					chan_q    <= $signed({5'b0, ic0_q} * {5'b0, w2_q});
					row_off_q <= r0_ext * $signed({11'b0, cfg.in_width});
					wptr_q    <= WGT_AW'({4'b0, oig_q} * {8'b0, kk_q});
					state_q   <= B_SET3;
				end
				B_SET3: begin
					row_base_q <= chan_q + row_off_q;
					r_cur_q    <= r0_q;
					c_cur_q    <= c0_q;
					k_q        <= 5'd0;
					kr_q       <= 3'd0;
					kc_q       <= 3'd0;
					state_q    <= B_RUN;
				end
				B_RUN: begin
					// weights are laid out in walk order, so one pointer steps by one
					wptr_q <= wptr_q + 1'b1;
					if (last_kc) begin
						kc_q    <= 3'd0;
						c_cur_q <= c0_q;
						if (last_kr) begin
							kr_q       <= 3'd0;
							r_cur_q    <= r0_q;
							chan_q     <= chan_q + $signed({5'b0, w2_q});
							row_base_q <= chan_q + $signed({5'b0, w2_q}) + row_off_q;
							if (last_k) begin
								drain_q <= 1'b0;
								state_q <= B_DRAIN;
							end else begin
								k_q <= k_q + 5'd1;
							end
						end else begin
							kr_q       <= kr_q + 3'd1;
							r_cur_q    <= r_cur_q + 11'sd1;
							row_base_q <= row_base_q + $signed({11'b0, cfg.in_width});
						end
					end else begin
						kc_q    <= kc_q + 3'd1;
						c_cur_q <= c_cur_q + 11'sd1;
					end
				end
				B_DRAIN: begin
					if (drain_q) begin
						state_q <= B_BIAS;
					end else begin
						drain_q <= 1'b1;
					end
				end
				B_BIAS: begin
					if (cfg.bias_enable) begin
						acc_q <= acc_q + {{24{bias_rd_q[15]}}, bias_rd_q, 8'b0};
					end
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_free) begin
						res_q.result_value <= bad_q ? 32'sd0 : sat_val;
						res_q.status       <= bad_q;
						state_q            <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			// a new result item loads the output register, else a taken one clears it
			if (state_q == B_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (tap_s2) begin
				acc_q <= acc_q + {{16{prod_s2[31]}}, prod_s2};
			end
		end
	end

endmodule
`default_nettype wire

### rtl/grouped_conv2d_engine.sv
// Grouped 2D convolution engine. Items enter on item_valid/item_ready: modes weight,
// bias and activation load write one store word at the given index (loads beyond
// a store are dropped) and give no result; a read names one output element by
// its flat index oc*OW*OW + row*OW + col and gives exactly one result on
// res_valid/res_ready, a Q16.16 sum saturated to 32 bits, or zero with status 1
// for a bad configuration or an index out of range. Registers are written on the
// cfg port (always ready); the user must write them only while the engine is idle,
// and the block itself does not enforce it. A front end decodes each read with a
// shared subtract-and-count divider, whose run depends on channel counts, map size
// and stride; loads pass it without dividing. A four-entry queue lets it run ahead
// of the back end, whose single multiply-accumulate walks group channels times
// kernel taps, one tap a cycle, after setup steps and before drain and bias steps.
// Store contents are undefined until written; there is no clearing pass after reset.
`default_nettype none
module grouped_conv2d_engine import gconv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire item_t      item,
	output logic            res_valid,
	input  wire logic       res_ready,
	output res_t            res,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [5:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t queue_cmd;
	logic queue_valid;
	logic queue_ready;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_channels  <= 5'd1;
			cfg_q.out_channels <= 5'd1;
			cfg_q.in_width     <= 6'd32;
			cfg_q.kernel_width <= 3'd3;
			cfg_q.pad_width    <= 2'd1;
			cfg_q.stride_step  <= 3'd1;
			cfg_q.group_count  <= 5'd1;
			cfg_q.bias_enable  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IN_CH:  cfg_q.in_channels  <= cfg_data[4:0];
				REG_OUT_CH: cfg_q.out_channels <= cfg_data[4:0];
				REG_WIDTH:  cfg_q.in_width     <= cfg_data;
				REG_KERNEL: cfg_q.kernel_width <= cfg_data[2:0];
				REG_PAD:    cfg_q.pad_width    <= cfg_data[1:0];
				REG_STRIDE: cfg_q.stride_step  <= cfg_data[2:0];
				REG_GROUPS: cfg_q.group_count  <= cfg_data[4:0];
				REG_BIAS:   cfg_q.bias_enable  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front: accept and classify items, decode read indexes
	gconv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.cmd        (front_cmd),
		.cmd_valid  (front_valid),
		.cmd_ready  (front_ready)
	);

	// decoupling queue
	gconv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (queue_cmd),
		.pop_valid  (queue_valid),
		.pop_ready  (queue_ready)
	);

	// back: stores, multiply-accumulate walk and output register
	gconv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (queue_cmd),
		.cmd_valid (queue_valid),
		.cmd_ready (queue_ready),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

endmodule
`default_nettype wire

### rtl/gconv_chk.sv
// port-level checks of the grouped convolution engine and their binding
`default_nettype none
module gconv_chk import gconv_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_ready,
	input wire item_t      item,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire res_t       res,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [5:0] cfg_data
);

	// a stalled result item holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result item changed while stalled");

	// an error result carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status |-> res.result_value == 32'sd0)
		else $error("error result with nonzero value");

	// register port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg port not ready");

	// no result straight out of reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !res_valid)
		else $error("result item right after reset");

endmodule

bind grouped_conv2d_engine gconv_chk u_gconv_chk (.*);
`default_nettype wire

### test/grouped_conv2d_checker.sv
// item and result monitor with a convolution predictor and in-order result compare
`default_nettype none
module grouped_conv2d_checker import gconv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire logic       item_ready,
	input  wire item_t      item,
	input  wire logic       res_valid,
	input  wire logic       res_ready,
	input  wire res_t       res,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [5:0] cfg_data,
	output int              failures,
	output int              outstanding,
	output int              reads_seen,
	output int              loads_seen
);

	logic signed [15:0] act_mem [ACT_DEPTH];
	logic signed [15:0] wgt_mem [WGT_DEPTH];
	logic signed [15:0] bias_mem [BIAS_DEPTH];
	cfg_t settings;
	res_t pending_results [$];

	initial begin
		foreach (act_mem[i]) act_mem[i] = '0;
		foreach (wgt_mem[i]) wgt_mem[i] = '0;
		foreach (bias_mem[i]) bias_mem[i] = '0;
	end

	function automatic res_t conv_element(int idx);
		int cin, cout, w, k, p, s, g;
		int ow, osz, oc, pos, orow, ocol, ig, og, grp, ic, r, c, ai, wi;
		longint acc;
		res_t o;
		cin = settings.in_channels;
		cout = settings.out_channels;
		w = settings.in_width;
		k = settings.kernel_width;
		p = settings.pad_width;
		s = settings.stride_step;
		g = settings.group_count;
		o.result_value = '0;
		o.status = 1'b1;
		if (cin < 1 || cin > MAX_CHANNELS || cout < 1 || cout > MAX_CHANNELS) return o;
		if (w < 1 || w > MAX_WIDTH || k < 1 || k > MAX_KERNEL || s < 1 || g < 1) return o;
		if ((cin % g) != 0 || (cout % g) != 0) return o;
		if (w + 2 * p < k) return o;
		ow = (w + 2 * p - k) / s + 1;
		osz = ow * ow;
		if (idx >= cout * osz) return o;
		oc = idx / osz;
		pos = idx % osz;
		orow = pos / ow;
		ocol = pos % ow;
		ig = cin / g;
		og = cout / g;
		grp = oc / og;
		acc = 0;
		for (int ch = 0; ch < ig; ch++) begin
			ic = grp * ig + ch;
			for (int kr = 0; kr < k; kr++) begin
				r = orow * s + kr - p;
				if (r < 0 || r >= w) continue;
				for (int kc = 0; kc < k; kc++) begin
					c = ocol * s + kc - p;
					if (c < 0 || c >= w) continue;
					ai = ic * w * w + r * w + c;
					wi = ((oc * ig + ch) * k + kr) * k + kc;
					if (ai >= ACT_DEPTH || wi >= WGT_DEPTH) continue;
					acc += longint'(act_mem[ai]) * longint'(wgt_mem[wi]);
				end
			end
		end
		if (settings.bias_enable && oc < BIAS_DEPTH)
			acc += longint'(bias_mem[oc]) * 256;
		if (acc > 64'sd2147483647) acc = 64'sd2147483647;
		if (acc < -64'sd2147483648) acc = -64'sd2147483648;
		o.result_value = acc[31:0];
		o.status = 1'b0;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			settings <= '{in_channels: 5'd1, out_channels: 5'd1, in_width: 6'd32,
				kernel_width: 3'd3, pad_width: 2'd1, stride_step: 3'd1,
				group_count: 5'd1, bias_enable: 1'b0};
			failures <= 0;
			outstanding <= 0;
			reads_seen <= 0;
			loads_seen <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result: got value %0d status %0b",
						$time, res.result_value, res.status);
					failures <= failures + 1;
				end else begin
					want = pending_results.pop_front();
					if (want.result_value !== res.result_value || want.status !== res.status) begin
						$display("%0t mismatch: expected value %0d status %0b, got value %0d status %0b",
							$time, want.result_value, want.status, res.result_value, res.status);
						failures <= failures + 1;
					end
				end
			end
			if (item_valid && item_ready) begin
				case (item.mode)
					MODE_WGT: if (item.index < WGT_DEPTH) wgt_mem[item.index] = item.value;
					MODE_BIAS: if (item.index < BIAS_DEPTH) bias_mem[item.index] = item.value;
					MODE_ACT: if (item.index < ACT_DEPTH) act_mem[item.index] = item.value;
					default: pending_results.push_back(conv_element(item.index));
				endcase
				if (item.mode == MODE_READ) reads_seen <= reads_seen + 1;
				else loads_seen <= loads_seen + 1;
			end
			outstanding <= pending_results.size();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IN_CH: settings.in_channels <= cfg_data[4:0];
					REG_OUT_CH: settings.out_channels <= cfg_data[4:0];
					REG_WIDTH: settings.in_width <= cfg_data[5:0];
					REG_KERNEL: settings.kernel_width <= cfg_data[2:0];
					REG_PAD: settings.pad_width <= cfg_data[1:0];
					REG_STRIDE: settings.stride_step <= cfg_data[2:0];
					REG_GROUPS: settings.group_count <= cfg_data[4:0];
					default: settings.bias_enable <= cfg_data[0];
				endcase
			end
		end
	end

endmodule
`default_nettype wire

### test/grouped_conv2d_engine_tb.sv
// stimulus and verdict for the grouped convolution engine
`default_nettype none
module grouped_conv2d_engine_tb;
	import gconv_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	item_t      item = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_t       res;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = REG_IN_CH;
	logic [5:0] cfg_data = '0;

	int failures, outstanding, reads_seen, loads_seen;

	// idle percentages for each side, changed as the run goes on
	int send_idle = 0;
	int recv_idle = 0;
	int items_sent = 0;
	int settings_used = 0;
	cfg_t active;

	grouped_conv2d_engine dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	grouped_conv2d_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.failures(failures), .outstanding(outstanding),
		.reads_seen(reads_seen), .loads_seen(loads_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side stalls at random
	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_idle);
	end

	// hard stop in case the engine hangs
	initial begin
		#100000000;
		$display("tb: failure");
		$finish;
	end

	function automatic void update_idling();
		if (items_sent < 650) begin
			send_idle = 11;
			recv_idle = 73;
		end else if (items_sent < 1300) begin
			send_idle = 73;
			recv_idle = 11;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	endfunction

	// one item; valid stays high into the next item unless a gap is drawn
	task automatic send_item(logic [1:0] mode, int idx, logic [15:0] val);
		update_idling();
		if ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		item_valid <= 1'b1;
		item <= '{mode: mode, index: idx[13:0], value: val};
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	// data words: extremes, full range and small values
	function automatic logic [15:0] pick_value();
		int r;
		r = $urandom_range(15);
		if (r == 0) return 16'h7fff;
		if (r == 1) return 16'h8000;
		if (r < 9) return 16'($urandom_range(16'hffff));
		return 16'($urandom_range(1023) - 512);
	endfunction

	function automatic int side_of(cfg_t c);
		return (c.in_width + 2 * c.pad_width - c.kernel_width) / c.stride_step + 1;
	endfunction

	// lower valid, let results drain and the engine settle before registers change
	task automatic wait_idle();
		int guard;
		item_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (outstanding != 0 && guard < 400000) begin
			@(posedge clk);
			guard++;
		end
		repeat (700) @(posedge clk);
	endtask

	task automatic apply_settings(cfg_t c);
		logic [5:0] vals [8];
		vals[REG_IN_CH] = 6'(c.in_channels);
		vals[REG_OUT_CH] = 6'(c.out_channels);
		vals[REG_WIDTH] = c.in_width;
		vals[REG_KERNEL] = 6'(c.kernel_width);
		vals[REG_PAD] = 6'(c.pad_width);
		vals[REG_STRIDE] = 6'(c.stride_step);
		vals[REG_GROUPS] = 6'(c.group_count);
		vals[REG_BIAS] = 6'(c.bias_enable);
		wait_idle();
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		active = c;
		settings_used++;
	endtask

	// fill every store word that a read under these settings can touch
	task automatic preload();
		int ig;
		ig = active.in_channels / active.group_count;
		for (int i = 0; i < active.in_channels * active.in_width * active.in_width; i++)
			send_item(MODE_ACT, i, pick_value());
		for (int i = 0; i < active.out_channels * ig * active.kernel_width * active.kernel_width; i++)
			send_item(MODE_WGT, i, pick_value());
		for (int i = 0; i < active.out_channels; i++)
			send_item(MODE_BIAS, i, pick_value());
	endtask

	// random traffic; good settings aim most loads and reads at the filled region
	task automatic random_items(int count, bit good);
		int r, outs, ig, act_used, wgt_used;
		outs = good ? active.out_channels * side_of(active) * side_of(active) : 1;
		ig = good ? active.in_channels / active.group_count : 1;
		act_used = active.in_channels * active.in_width * active.in_width;
		wgt_used = active.out_channels * ig * active.kernel_width * active.kernel_width;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 45)
				send_item(MODE_READ, good ? $urandom_range(outs - 1) : $urandom_range(16383),
					16'($urandom_range(16'hffff)));
			else if (r < 50)
				send_item(MODE_READ, $urandom_range(16383), 16'($urandom_range(16'hffff)));
			else if (!good)
				send_item(2'($urandom_range(2)), $urandom_range(16383), pick_value());
			else if (r < 65)
				send_item(MODE_ACT, $urandom_range(act_used - 1), pick_value());
			else if (r < 78)
				send_item(MODE_WGT, $urandom_range(wgt_used - 1), pick_value());
			else if (r < 83)
				send_item(MODE_BIAS, $urandom_range(active.out_channels - 1), pick_value());
			else if (r < 88)
				send_item(MODE_WGT, $urandom_range(16383, WGT_DEPTH), pick_value());
			else if (r < 92)
				send_item(MODE_BIAS, $urandom_range(16383, BIAS_DEPTH), pick_value());
			else
				send_item(MODE_ACT, $urandom_range(16383), pick_value());
		end
	endtask

	initial begin
		cfg_t good_cfgs [5];
		cfg_t bad_cfgs [10];
		int good_counts [5];
		int last_out;

		// in, out, width, kernel, pad, stride, groups, bias
		good_cfgs[0] = '{4, 4, 6, 3, 1, 1, 2, 1};
		good_cfgs[1] = '{16, 16, 3, 3, 2, 4, 16, 1};
		good_cfgs[2] = '{1, 1, 3, 5, 2, 1, 1, 1};
		good_cfgs[3] = '{2, 6, 5, 4, 2, 3, 2, 1};
		good_cfgs[4] = '{8, 8, 4, 2, 0, 2, 4, 0};
		good_counts = '{200, 120, 80, 200, 150};

		// broken settings: each trips a different configuration check
		bad_cfgs[0] = '{0, 1, 4, 3, 1, 1, 1, 0};
		bad_cfgs[1] = '{17, 17, 4, 3, 1, 1, 1, 1};
		bad_cfgs[2] = '{1, 1, 0, 1, 0, 1, 1, 0};
		bad_cfgs[3] = '{1, 1, 33, 3, 1, 1, 1, 0};
		bad_cfgs[4] = '{1, 1, 4, 0, 1, 1, 1, 0};
		bad_cfgs[5] = '{1, 1, 8, 6, 1, 1, 1, 0};
		bad_cfgs[6] = '{2, 2, 4, 3, 1, 0, 1, 0};
		bad_cfgs[7] = '{4, 4, 4, 3, 1, 1, 3, 1};
		bad_cfgs[8] = '{2, 2, 4, 3, 1, 1, 0, 0};
		bad_cfgs[9] = '{1, 1, 1, 5, 0, 1, 1, 0};

		active = '{1, 1, 32, 3, 1, 1, 1, 0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, no register write yet: the first output row
		// only touches the first two map rows
		for (int i = 0; i < 64; i++)
			send_item(MODE_ACT, i, pick_value());
		for (int i = 0; i < 9; i++)
			send_item(MODE_WGT, i, pick_value());
		send_item(MODE_BIAS, 0, pick_value());
		send_item(MODE_READ, 0, 16'h0000);
		send_item(MODE_READ, 17, 16'h0000);
		send_item(MODE_READ, 31, 16'h0000);
		send_item(MODE_READ, 1024, 16'h0000);

		// small grouped map with the directed corners first
		apply_settings(good_cfgs[0]);
		preload();
		last_out = active.out_channels * side_of(active) * side_of(active) - 1;
		send_item(MODE_READ, 0, 16'h0000);
		send_item(MODE_READ, last_out, 16'hffff);
		send_item(MODE_READ, last_out + 1, 16'h0000);
		send_item(MODE_READ, 16383, 16'h0000);
		send_item(MODE_WGT, WGT_DEPTH - 1, 16'h7fff);
		send_item(MODE_WGT, WGT_DEPTH, 16'h1234);
		send_item(MODE_WGT, 16383, 16'h8000);
		send_item(MODE_BIAS, BIAS_DEPTH, 16'h7fff);
		send_item(MODE_ACT, 16383, 16'h8000);
		// corner taps of output 0 with padding: both channels at the most negative word
		for (int ch = 0; ch < 2; ch++) begin
			send_item(MODE_ACT, ch * 36 + 0, 16'h8000);
			send_item(MODE_ACT, ch * 36 + 7, 16'h8000);
			send_item(MODE_WGT, ch * 9 + 4, 16'h8000);
			send_item(MODE_WGT, ch * 9 + 8, 16'h8000);
		end
		send_item(MODE_BIAS, 0, 16'h7fff);
		send_item(MODE_READ, 0, 16'h0000);
		send_item(MODE_WGT, 4, 16'h7fff);
		send_item(MODE_WGT, 13, 16'h7fff);
		send_item(MODE_BIAS, 0, 16'h8000);
		send_item(MODE_READ, 0, 16'h0000);
		random_items(good_counts[0], 1'b1);

		for (int i = 1; i < 5; i++) begin
			apply_settings(good_cfgs[i]);
			preload();
			random_items(good_counts[i], 1'b1);
			// broken settings in between; stores are not read under them
			apply_settings(bad_cfgs[2 * i - 2]);
			random_items(20, 1'b0);
			apply_settings(bad_cfgs[2 * i - 1]);
			random_items(20, 1'b0);
		end
		apply_settings(bad_cfgs[8]);
		random_items(20, 1'b0);
		apply_settings(bad_cfgs[9]);
		random_items(20, 1'b0);

		// drain and let the engine settle
		wait_idle();
		repeat (500) @(posedge clk);

		$display("run covered %0d reads and %0d loads over %0d register settings",
			reads_seen, loads_seen, settings_used + 1);
		$display("including broken settings, padding, strides, groups and saturation");
		if (failures == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
rtl/gconv_pkg.sv
rtl/gconv_front.sv
rtl/gconv_queue.sv
rtl/gconv_back.sv
rtl/grouped_conv2d_engine.sv
rtl/gconv_chk.sv
test/grouped_conv2d_checker.sv
test/grouped_conv2d_engine_tb.sv
